>>> hdl/paxy_pkg.sv
`default_nettype none

package paxy_pkg;

  // Coordinates are normalized so that the input sign bit lands at bit 55.
  localparam int SCALE_EXP = 56;
  // Datapath width: folded magnitude below 2^56, CORDIC gain below 1.65, plus margin.
  localparam int XW = 59;
  // Angle accumulator: signed Q.30 radians, spans about -1.75 to 4.9.
  localparam int ZW = 34;
  localparam int ATAN_LEN = 24;

  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] THREE_HALF_PI_Q30 = 34'sd5059889139;
  localparam logic signed [ZW-1:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [ZW-1:0] ROUND_Q30 = 34'sd65536;
  localparam logic [15:0] TWO_PI_Q13 = 16'd51472;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic hold;
    logic origin;
  } cordic_t;

  // Round-to-nearest of atan(2^-step) in Q.30.
  function automatic logic signed [ZW-1:0] atan_q30(input int step);
    logic signed [ZW-1:0] r;
    case (step)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/paxy_prep.sv
`default_nettype none

module paxy_prep import paxy_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [COORD_WIDTH-1:0] x_coord,
  input  wire logic signed [COORD_WIDTH-1:0] y_coord,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  output logic                               out_valid,
  output cordic_t                            out_data,
  input  wire logic                          out_ready
);

  localparam int SHIFT = SCALE_EXP - COORD_WIDTH;

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic x_zero;
  logic y_zero;
  logic x_neg;
  cordic_t data_next;

  assign x_ext = XW'(x_coord);
  assign y_ext = XW'(y_coord);
  assign x_zero = (x_coord == '0);
  assign y_zero = (y_coord == '0);
  assign x_neg = x_coord[COORD_WIDTH-1];

  always_comb begin
    data_next.origin = x_zero && y_zero;
    data_next.hold = x_zero || y_zero;
    // The left half plane is turned by 180 degrees; at this width negation cannot overflow.
    if (x_neg) begin
      data_next.x = (-x_ext) <<< SHIFT;
      data_next.y = (-y_ext) <<< SHIFT;
    end else begin
      data_next.x = x_ext <<< SHIFT;
      data_next.y = y_ext <<< SHIFT;
    end
    if (x_zero && y_zero) begin
      data_next.z = '0;
    end else if (y_zero) begin
      data_next.z = x_neg ? PI_Q30 : '0;
    end else if (x_zero) begin
      data_next.z = y_coord[COORD_WIDTH-1] ? THREE_HALF_PI_Q30 : HALF_PI_Q30;
    end else begin
      data_next.z = x_neg ? PI_Q30 : '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/paxy_stage.sv
`default_nettype none

module paxy_stage import paxy_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire cordic_t in_data,
  output logic         in_ready,
  output logic         out_valid,
  output cordic_t      out_data,
  input  wire logic    out_ready
);

  localparam logic signed [ZW-1:0] ATAN = atan_q30(STEP);

  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  cordic_t data_next;

  // Arithmetic shifts floor toward minus infinity.
  assign x_sh = in_data.x >>> STEP;
  assign y_sh = in_data.y >>> STEP;

  always_comb begin
    data_next = in_data;
    // Axis cases already carry their exact angle and skip the rotation.
    if (!in_data.hold) begin
      if (!in_data.y[XW-1]) begin
        data_next.x = in_data.x + y_sh;
        data_next.y = in_data.y - x_sh;
        data_next.z = in_data.z + ATAN;
      end else begin
        data_next.x = in_data.x - y_sh;
        data_next.y = in_data.y + x_sh;
        data_next.z = in_data.z - ATAN;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/paxy_round.sv
`default_nettype none

module paxy_round import paxy_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire cordic_t in_data,
  output logic         in_ready,
  output logic         out_valid,
  output logic [15:0]  angle,
  output logic         undefined_origin,
  input  wire logic    out_ready
);

  logic signed [ZW-1:0] sum_pos;
  logic signed [ZW-1:0] sum_wrap;
  logic signed [ZW-1:0] sum_sel;
  logic [15:0] q;
  logic [15:0] angle_next;

  // Both the plain and the 2pi-wrapped sums are formed; the sign picks one.
  assign sum_pos = in_data.z + ROUND_Q30;
  assign sum_wrap = in_data.z + TWO_PI_Q30 + ROUND_Q30;
  assign sum_sel = in_data.z[ZW-1] ? sum_wrap : sum_pos;
  assign q = sum_sel[32:17];
  assign angle_next = (q >= TWO_PI_Q13) ? q - TWO_PI_Q13 : q;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle <= angle_next;
      undefined_origin <= in_data.origin;
    end
  end

endmodule

`default_nettype wire

>>> hdl/polar_angle_from_xy.sv
// Channel   Handshake                  Payload
// coord     coord_valid, coord_ready   x_coord, y_coord (signed, COORD_WIDTH bits)
// result    angle_valid, angle_ready   angle (Q3.13 radians), undefined_origin
//
// The pipeline holds one input stage, one register per CORDIC micro-rotation,
// and one rounding stage. A new transaction is taken every cycle unless stalled.
// Reset (rst, synchronous) empties the pipeline; data registers are not cleared.
// Each stage advances when the one after it is empty or moving, so a stall on
// angle_ready backs up stage by stage and bubbles are squeezed out.
`default_nettype none

module polar_angle_from_xy import paxy_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic signed [COORD_WIDTH-1:0] x_coord,
  input  wire logic signed [COORD_WIDTH-1:0] y_coord,
  input  wire logic                          coord_valid,
  output logic                               coord_ready,
  output logic [15:0]                        angle,
  output logic                               undefined_origin,
  output logic                               angle_valid,
  input  wire logic                          angle_ready
);

  cordic_t pipe_data [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] pipe_valid;
  logic [CORDIC_STEPS:0] pipe_ready;

  paxy_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .in_valid  (coord_valid),
    .in_ready  (coord_ready),
    .out_valid (pipe_valid[0]),
    .out_data  (pipe_data[0]),
    .out_ready (pipe_ready[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    paxy_stage #(
      .STEP(k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pipe_valid[k]),
      .in_data   (pipe_data[k]),
      .in_ready  (pipe_ready[k]),
      .out_valid (pipe_valid[k+1]),
      .out_data  (pipe_data[k+1]),
      .out_ready (pipe_ready[k+1])
    );
  end

  paxy_round u_round (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (pipe_valid[CORDIC_STEPS]),
    .in_data          (pipe_data[CORDIC_STEPS]),
    .in_ready         (pipe_ready[CORDIC_STEPS]),
    .out_valid        (angle_valid),
    .angle            (angle),
    .undefined_origin (undefined_origin),
    .out_ready        (angle_ready)
  );

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    angle_valid && undefined_origin |-> angle == '0)
    else $error("origin result carries a nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> angle < TWO_PI_Q13)
    else $error("angle at or above 2pi");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !coord_ready |-> angle_valid && !angle_ready)
    else $error("input held off without an output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !angle_valid && coord_ready)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;
  import paxy_pkg::*;

  localparam int COORD_WIDTH = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = CORDIC_STEPS + 20;

  // Angle constants in Q.30 and Q3.13 radians.
  localparam longint PI_Z = 64'sd3373259426;
  localparam longint HALF_PI_Z = 64'sd1686629713;
  localparam longint THREE_HALF_PI_Z = 64'sd5059889139;
  localparam longint FULL_TURN_Z = 64'sd6746518852;
  localparam longint FULL_TURN_Q13 = 64'sd51472;
  localparam logic [15:0] ANGLE_ZERO = 16'd0;
  localparam logic [15:0] ANGLE_HALF_PI = 16'd12868;
  localparam logic [15:0] ANGLE_PI = 16'd25736;
  localparam logic [15:0] ANGLE_THREE_HALF_PI = 16'd38604;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    bit known;
    logic [15:0] angle;
    logic origin;
  } coord_case_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [15:0] angle;
    logic origin;
  } angle_result_t;

  logic clk;
  logic rst;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic coord_valid;
  logic coord_ready;
  logic [15:0] angle;
  logic undefined_origin;
  logic angle_valid;
  logic angle_ready;

  // Round-to-nearest atan(2^-i) in Q.30.
  longint atan_step [24] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  coord_case_t directed_cases[$];
  angle_result_t pending_angles[$];
  angle_result_t oldest;
  int mismatch_count = 0;
  int checked_count = 0;
  int origin_count = 0;
  int sent_count = 0;
  bit sink_steady = 0;
  int stall_left = 0;
  int sink_cycles = 0;

  polar_angle_from_xy #(
    .COORD_WIDTH(COORD_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .coord_valid(coord_valid),
    .coord_ready(coord_ready),
    .angle(angle),
    .undefined_origin(undefined_origin),
    .angle_valid(angle_valid),
    .angle_ready(angle_ready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("%0t: timed out with %0d angles outstanding", $time, pending_angles.size());
    $display("testbench NOT OK");
    $finish;
  end

  // Full-turn atan2 by vectoring CORDIC on a left-half-plane fold.
  function automatic void polar_angle_q13(input logic signed [COORD_WIDTH-1:0] xin,
                                          input logic signed [COORD_WIDTH-1:0] yin,
                                          output logic [15:0] ang,
                                          output logic org);
    longint xa;
    longint ya;
    longint za;
    longint xs;
    longint ys;
    longint q;
    xa = xin;
    ya = yin;
    org = 1'b0;
    if (xa == 0 && ya == 0) begin
      ang = ANGLE_ZERO;
      org = 1'b1;
      return;
    end
    if (ya == 0) begin
      za = (xa > 0) ? 0 : PI_Z;
    end else if (xa == 0) begin
      za = (ya > 0) ? HALF_PI_Z : THREE_HALF_PI_Z;
    end else begin
      za = 0;
      if (xa < 0) begin
        xa = -xa;
        ya = -ya;
        za = PI_Z;
      end
      xa = xa * (64'sd1 <<< (SCALE_EXP - COORD_WIDTH));
      ya = ya * (64'sd1 <<< (SCALE_EXP - COORD_WIDTH));
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        xs = xa >>> i;
        ys = ya >>> i;
        if (ya >= 0) begin
          xa = xa + ys;
          ya = ya - xs;
          za = za + atan_step[i];
        end else begin
          xa = xa - ys;
          ya = ya + xs;
          za = za - atan_step[i];
        end
      end
      if (za < 0) za = za + FULL_TURN_Z;
    end
    q = (za + 64'sd65536) >>> 17;
    if (q >= FULL_TURN_Q13) q = q - FULL_TURN_Q13;
    ang = q[15:0];
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pause_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] corner_value();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  task automatic add_case(input logic signed [COORD_WIDTH-1:0] x,
                          input logic signed [COORD_WIDTH-1:0] y,
                          input bit known, input logic [15:0] ang, input logic org);
    coord_case_t c;
    c.x = x;
    c.y = y;
    c.known = known;
    c.angle = ang;
    c.origin = org;
    directed_cases.push_back(c);
  endtask

  task automatic pick_coords(output logic signed [COORD_WIDTH-1:0] x,
                             output logic signed [COORD_WIDTH-1:0] y);
    int mag;
    x = COORD_WIDTH'($urandom);
    y = COORD_WIDTH'($urandom);
    case ($urandom_range(0, 9))
      4: begin
        x = COORD_WIDTH'(int'($urandom_range(0, 8)) - 4);
        y = COORD_WIDTH'(int'($urandom_range(0, 8)) - 4);
      end
      5: begin
        if ($urandom_range(0, 1)) x = 0;
        else y = 0;
      end
      6: begin
        // Close to an axis, where the angle sits near 0, pi/2, pi, 3pi/2 or the wrap at 2pi.
        if ($urandom_range(0, 1)) y = COORD_WIDTH'(int'($urandom_range(0, 4)) - 2);
        else x = COORD_WIDTH'(int'($urandom_range(0, 4)) - 2);
      end
      7: begin
        x = corner_value();
        y = corner_value();
      end
      8: y = $urandom_range(0, 1) ? x : -x;
      9: begin
        mag = $urandom_range(0, 14);
        x = x >>> mag;
        y = y >>> $urandom_range(0, 14);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && angle_valid && angle_ready) begin
      checked_count++;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected angle %0d origin %0d", $time, angle, undefined_origin);
        mismatch_count++;
      end else begin
        oldest = pending_angles.pop_front();
        if (angle !== oldest.angle) begin
          $display("%0t: angle of (%0d,%0d) expected %0d got %0d", $time,
                   oldest.x, oldest.y, oldest.angle, angle);
          mismatch_count++;
        end
        if (undefined_origin !== oldest.origin) begin
          $display("%0t: undefined_origin of (%0d,%0d) expected %0b got %0b", $time,
                   oldest.x, oldest.y, oldest.origin, undefined_origin);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random stalls, with stretches of steady readiness.
  initial begin
    angle_ready <= 1'b0;
    forever begin
      @(posedge clk);
      sink_cycles++;
      if (sink_cycles % 300 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        angle_ready <= 1'b0;
        stall_left--;
      end else begin
        angle_ready <= 1'b1;
        if (!sink_steady) stall_left = pause_cycles();
      end
    end
  end

  initial begin
    logic signed [COORD_WIDTH-1:0] nx;
    logic signed [COORD_WIDTH-1:0] ny;
    angle_result_t want;
    coord_case_t c;
    int gap;
    int total;
    bit src_steady;

    rst <= 1'b1;
    coord_valid <= 1'b0;
    x_coord <= '0;
    y_coord <= '0;

    add_case(16'sd0, 16'sd0, 1, ANGLE_ZERO, 1'b1);
    add_case(16'sd1, 16'sd0, 1, ANGLE_ZERO, 1'b0);
    add_case(16'sd32767, 16'sd0, 1, ANGLE_ZERO, 1'b0);
    add_case(-16'sd1, 16'sd0, 1, ANGLE_PI, 1'b0);
    add_case(-16'sd32768, 16'sd0, 1, ANGLE_PI, 1'b0);
    add_case(16'sd0, 16'sd1, 1, ANGLE_HALF_PI, 1'b0);
    add_case(16'sd0, 16'sd32767, 1, ANGLE_HALF_PI, 1'b0);
    add_case(16'sd0, -16'sd1, 1, ANGLE_THREE_HALF_PI, 1'b0);
    add_case(16'sd0, -16'sd32768, 1, ANGLE_THREE_HALF_PI, 1'b0);
    add_case(-16'sd32768, -16'sd32768, 0, '0, 1'b0);
    add_case(16'sd32767, 16'sd32767, 0, '0, 1'b0);
    add_case(-16'sd32768, 16'sd32767, 0, '0, 1'b0);
    add_case(16'sd32767, -16'sd32768, 0, '0, 1'b0);
    add_case(16'sd1, 16'sd1, 0, '0, 1'b0);
    add_case(16'sd1, -16'sd1, 0, '0, 1'b0);
    add_case(-16'sd1, 16'sd1, 0, '0, 1'b0);
    add_case(-16'sd1, -16'sd1, 0, '0, 1'b0);
    add_case(16'sd32767, -16'sd1, 0, '0, 1'b0);
    add_case(16'sd32767, 16'sd1, 0, '0, 1'b0);
    add_case(-16'sd32768, 16'sd1, 0, '0, 1'b0);
    add_case(-16'sd32768, -16'sd1, 0, '0, 1'b0);
    add_case(16'sd1, 16'sd32767, 0, '0, 1'b0);
    add_case(-16'sd1, -16'sd32768, 0, '0, 1'b0);
    add_case(16'sh5555, -16'sh2AAB, 0, '0, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    total = directed_cases.size() + RANDOM_ITEMS;
    src_steady = 0;
    for (int n = 0; n < total; n++) begin
      if (n < directed_cases.size()) begin
        c = directed_cases[n];
        nx = c.x;
        ny = c.y;
      end else begin
        c.known = 0;
        pick_coords(nx, ny);
      end
      if (n % 150 == 0) src_steady = ($urandom_range(0, 3) == 0);
      gap = src_steady ? 0 : pause_cycles();
      if (gap > 0) begin
        coord_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      x_coord <= nx;
      y_coord <= ny;
      coord_valid <= 1'b1;
      @(posedge clk);
      while (!coord_ready) @(posedge clk);

      want.x = nx;
      want.y = ny;
      if (c.known) begin
        want.angle = c.angle;
        want.origin = c.origin;
      end else begin
        polar_angle_q13(nx, ny, want.angle, want.origin);
      end
      if (want.origin) origin_count++;
      pending_angles.push_back(want);
      sent_count++;
    end
    coord_valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d coordinate pairs (%0d directed, %0d at the origin), checked %0d angles.",
             sent_count, directed_cases.size(), origin_count, checked_count);
    $display("Found %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> polar_angle_from_xy.f
hdl/paxy_pkg.sv
hdl/paxy_prep.sv
hdl/paxy_stage.sv
hdl/paxy_round.sv
hdl/polar_angle_from_xy.sv
test/testbench.sv
